// File: src/lbmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_pkg
// Shared types, codes and timing constants of the LED blink mode controller.
// ----------------------------------------------------------------------------
package lbmc_pkg;

  localparam int NUM_LEDS_DEFAULT = 2;
  localparam int NUM_LEDS_MAX     = 16;

  localparam int CMD_W     = 1;
  localparam int LED_IDX_W = 1;
  localparam int MODE_W    = 4;
  localparam int LED_OUT_W = 2;
  localparam int MS_W      = 11;
  localparam int TOG_W     = 4;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [MS_W-1:0]      ms_t;
  typedef logic [TOG_W-1:0]     tog_t;
  typedef logic [LED_OUT_W-1:0] led_out_t;

  localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SET  = 1'b1;

  localparam mode_t MODE_OFF   = 4'd0;
  localparam mode_t MODE_ON    = 4'd1;
  localparam mode_t MODE_ON500 = 4'd2;
  localparam mode_t MODE_ON1S  = 4'd3;
  localparam mode_t MODE_ON2S  = 4'd4;
  localparam mode_t MODE_FL200 = 4'd5;
  localparam mode_t MODE_FL500 = 4'd6;
  localparam mode_t MODE_FL2S  = 4'd7;
  localparam mode_t MODE_BURST = 4'd8;

  localparam ms_t  MS_200  = 11'd200;
  localparam ms_t  MS_500  = 11'd500;
  localparam ms_t  MS_1000 = 11'd1000;
  localparam ms_t  MS_2000 = 11'd2000;

  localparam tog_t BURST_COUNT = 4'd10;

  // flash and burst half-period in ms
  function automatic ms_t half_period(mode_t m);
    ms_t r;
    case (m)
      MODE_FL200: r = MS_200;
      MODE_FL500: r = MS_500;
      MODE_FL2S:  r = MS_2000;
      MODE_BURST: r = MS_200;
      default:    r = '0;
    endcase
    return r;
  endfunction

  // lit time of the timed-on modes
  function automatic ms_t on_time(mode_t m);
    ms_t r;
    case (m)
      MODE_ON500: r = MS_500;
      MODE_ON1S:  r = MS_1000;
      default:    r = MS_2000;
    endcase
    return r;
  endfunction

endpackage

// File: src/lbmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_if
// Valid/ready channels of the LED blink mode controller: request and result.
// ----------------------------------------------------------------------------
interface lbmc_req_if;
  logic                             valid;
  logic                             ready;
  logic [lbmc_pkg::CMD_W-1:0]       command;
  logic [lbmc_pkg::LED_IDX_W-1:0]   led_index;
  logic [lbmc_pkg::MODE_W-1:0]      mode;

  modport source (output valid, output command, output led_index, output mode, input ready);
  modport sink   (input valid, input command, input led_index, input mode, output ready);
endinterface

interface lbmc_res_if;
  logic                             valid;
  logic                             ready;
  logic [lbmc_pkg::LED_OUT_W-1:0]   led_outputs;

  modport source (output valid, output led_outputs, input ready);
  modport sink   (input valid, input led_outputs, output ready);
endinterface

// File: src/led_blink_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_mode_controller
// Per-LED mode controller: 1 ms ticks run the countdowns, set-mode requests
// pick off, on, timed on, flash or burst. Every request returns the LED bits.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | accepted when
//  req     | in  | command, led_index, mode        | req.valid & req.ready
//  res     | out | led_outputs                     | res.valid & res.ready
//
//  One request per cycle while req.ready is high; results leave in order.
//  LED state is updated at the accepting edge, a two-entry result queue
//  holds results while res.ready is low, so req.ready drops only when both
//  entries are full. Synchronous reset darkens all LEDs and empties the queue.
// ----------------------------------------------------------------------------
module led_blink_mode_controller #(
  parameter int NUM_LEDS = lbmc_pkg::NUM_LEDS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  lbmc_req_if.sink     req,
  lbmc_res_if.source   res
);

  lbmc_pkg::mode_t led_mode      [NUM_LEDS];
  logic            led_lit       [NUM_LEDS];
  lbmc_pkg::ms_t   ms_remaining  [NUM_LEDS];
  lbmc_pkg::tog_t  toggles_left  [NUM_LEDS];
  logic            endless       [NUM_LEDS];

  lbmc_pkg::mode_t led_mode_next     [NUM_LEDS];
  logic            led_lit_next      [NUM_LEDS];
  lbmc_pkg::ms_t   ms_remaining_next [NUM_LEDS];
  lbmc_pkg::tog_t  toggles_left_next [NUM_LEDS];
  logic            endless_next      [NUM_LEDS];

  lbmc_pkg::led_out_t result;
  lbmc_pkg::led_out_t q0;
  lbmc_pkg::led_out_t q1;
  logic [1:0]         count;

  logic accept;
  logic pop;

  assign req.ready = (count != 2'd2);
  assign accept    = req.valid && req.ready;
  assign pop       = res.valid && res.ready;

  assign res.valid       = (count != 2'd0);
  assign res.led_outputs = q0;

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_mode_next[i]     = led_mode[i];
      led_lit_next[i]      = led_lit[i];
      ms_remaining_next[i] = ms_remaining[i];
      toggles_left_next[i] = toggles_left[i];
      endless_next[i]      = endless[i];
      if (accept) begin
        if (req.command == lbmc_pkg::CMD_TICK) begin
          if (ms_remaining[i] != '0) begin
            ms_remaining_next[i] = ms_remaining[i] - lbmc_pkg::MS_W'(1);
            // countdown reaches zero on this tick
            if (ms_remaining[i] == lbmc_pkg::MS_W'(1)) begin
              case (led_mode[i]) inside
                lbmc_pkg::MODE_OFF: led_lit_next[i] = 1'b0;
                lbmc_pkg::MODE_ON:  led_lit_next[i] = 1'b1;
                [lbmc_pkg::MODE_FL200:lbmc_pkg::MODE_BURST]: begin
                  led_lit_next[i] = ~led_lit[i];
                  if (endless[i]) begin
                    ms_remaining_next[i] = lbmc_pkg::half_period(led_mode[i]);
                  end else if (toggles_left[i] != '0) begin
                    toggles_left_next[i] = toggles_left[i] - lbmc_pkg::TOG_W'(1);
                    ms_remaining_next[i] = lbmc_pkg::half_period(led_mode[i]);
                  end
                end
                default: begin
                  led_mode_next[i] = lbmc_pkg::MODE_OFF;
                  led_lit_next[i]  = 1'b0;
                end
              endcase
            end
          end
        end else if (int'(req.led_index) == i) begin
          case (req.mode) inside
            lbmc_pkg::MODE_OFF: begin
              led_mode_next[i]     = lbmc_pkg::MODE_OFF;
              led_lit_next[i]      = 1'b0;
              ms_remaining_next[i] = '0;
            end
            lbmc_pkg::MODE_ON: begin
              led_mode_next[i]     = lbmc_pkg::MODE_ON;
              led_lit_next[i]      = 1'b1;
              ms_remaining_next[i] = '0;
            end
            [lbmc_pkg::MODE_ON500:lbmc_pkg::MODE_ON2S]: begin
              // expiry in mode off darkens the LED
              led_mode_next[i]     = lbmc_pkg::MODE_OFF;
              led_lit_next[i]      = 1'b1;
              ms_remaining_next[i] = lbmc_pkg::on_time(req.mode);
            end
            [lbmc_pkg::MODE_FL200:lbmc_pkg::MODE_BURST]: begin
              led_mode_next[i]     = req.mode;
              led_lit_next[i]      = 1'b1;
              ms_remaining_next[i] = lbmc_pkg::half_period(req.mode);
              endless_next[i]      = (req.mode != lbmc_pkg::MODE_BURST);
              toggles_left_next[i] = (req.mode == lbmc_pkg::MODE_BURST) ?
                                     lbmc_pkg::BURST_COUNT : '0;
            end
            default: begin
              // undefined mode codes leave the LED alone
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    result = '0;
    for (int j = 0; j < lbmc_pkg::LED_OUT_W && j < NUM_LEDS; j++) begin
      result[j] = led_lit_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]     <= lbmc_pkg::MODE_OFF;
        led_lit[i]      <= 1'b0;
        ms_remaining[i] <= '0;
        toggles_left[i] <= '0;
        endless[i]      <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]     <= led_mode_next[i];
        led_lit[i]      <= led_lit_next[i];
        ms_remaining[i] <= ms_remaining_next[i];
        toggles_left[i] <= toggles_left_next[i];
        endless[i]      <= endless_next[i];
      end
    end
  end

  // two-entry result queue, q0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({accept, pop})
        2'b11: begin
          if (count == 2'd1) begin
            q0 <= result;
          end else begin
            q0 <= q1;
            q1 <= result;
          end
        end
        2'b10: begin
          if (count == 2'd0) begin
            q0 <= result;
          end else begin
            q1 <= result;
          end
          count <= count + 2'd1;
        end
        2'b01: begin
          q0    <= q1;
          count <= count - 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/tb_led_blink_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_blink_mode_controller
// Sends tick and set-mode requests to the LED controller, with random gaps on
// both channels. A local copy of the per-LED state predicts the LED bits of
// every request, and the monitor compares each result with the oldest one.
// ----------------------------------------------------------------------------
module tb_led_blink_mode_controller;

  localparam int NUM_LEDS     = lbmc_pkg::NUM_LEDS_DEFAULT;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [15:0] TOGGLES_ENDLESS = 16'hffff;
  localparam int MODE_LAST_CODE = (1 << lbmc_pkg::MODE_W) - 1;

  typedef struct packed {
    logic [lbmc_pkg::CMD_W-1:0]     command;
    logic [lbmc_pkg::LED_IDX_W-1:0] led_index;
    lbmc_pkg::mode_t                mode;
  } led_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbmc_req_if req_ch();
  lbmc_res_if res_ch();

  led_blink_mode_controller #(.NUM_LEDS(NUM_LEDS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted per-LED state
  lbmc_pkg::mode_t led_mode_q [NUM_LEDS];
  logic            led_lit_q  [NUM_LEDS];
  lbmc_pkg::ms_t   ms_left_q  [NUM_LEDS];
  logic [15:0]     toggles_q  [NUM_LEDS];

  led_req_t           pending_reqs[$];
  lbmc_pkg::led_out_t expected_leds[$];
  led_req_t           cur_req;
  lbmc_pkg::led_out_t want_leds;
  logic               drv_busy;
  bit                 calm = 1'b0;
  int                 gap_left;
  int                 stall_left;
  int                 idle_cycles;
  int                 mismatches;
  int                 results_seen;
  int                 queued;

  function automatic lbmc_pkg::ms_t flash_interval(lbmc_pkg::mode_t m);
    if (m == lbmc_pkg::MODE_FL500) return lbmc_pkg::MS_500;
    if (m == lbmc_pkg::MODE_FL2S) return lbmc_pkg::MS_2000;
    return lbmc_pkg::MS_200;
  endfunction

  function automatic void expire_led(int i);
    if (led_mode_q[i] == lbmc_pkg::MODE_OFF) begin
      led_lit_q[i] = 1'b0;
    end else if (led_mode_q[i] == lbmc_pkg::MODE_ON) begin
      led_lit_q[i] = 1'b1;
    end else if (led_mode_q[i] >= lbmc_pkg::MODE_FL200 &&
                 led_mode_q[i] <= lbmc_pkg::MODE_BURST) begin
      led_lit_q[i] = ~led_lit_q[i];
      // burst stops once its toggle budget is spent
      if (toggles_q[i] != '0) begin
        if (toggles_q[i] != TOGGLES_ENDLESS) toggles_q[i] = toggles_q[i] - 16'd1;
        ms_left_q[i] = flash_interval(led_mode_q[i]);
      end
    end else begin
      led_mode_q[i] = lbmc_pkg::MODE_OFF;
      led_lit_q[i]  = 1'b0;
    end
  endfunction

  function automatic void set_led_mode(int i, lbmc_pkg::mode_t m);
    case (m)
      lbmc_pkg::MODE_OFF: begin
        led_mode_q[i] = lbmc_pkg::MODE_OFF;
        led_lit_q[i]  = 1'b0;
        ms_left_q[i]  = '0;
      end
      lbmc_pkg::MODE_ON: begin
        led_mode_q[i] = lbmc_pkg::MODE_ON;
        led_lit_q[i]  = 1'b1;
        ms_left_q[i]  = '0;
      end
      lbmc_pkg::MODE_ON500, lbmc_pkg::MODE_ON1S, lbmc_pkg::MODE_ON2S: begin
        // timed on parks the mode at off so the expiry darkens the LED
        led_mode_q[i] = lbmc_pkg::MODE_OFF;
        led_lit_q[i]  = 1'b1;
        ms_left_q[i]  = (m == lbmc_pkg::MODE_ON500) ? lbmc_pkg::MS_500 :
                        (m == lbmc_pkg::MODE_ON1S) ? lbmc_pkg::MS_1000 : lbmc_pkg::MS_2000;
      end
      lbmc_pkg::MODE_FL200, lbmc_pkg::MODE_FL500, lbmc_pkg::MODE_FL2S,
      lbmc_pkg::MODE_BURST: begin
        led_mode_q[i] = m;
        led_lit_q[i]  = 1'b1;
        toggles_q[i]  = (m == lbmc_pkg::MODE_BURST) ? 16'(lbmc_pkg::BURST_COUNT) :
                        TOGGLES_ENDLESS;
        ms_left_q[i]  = flash_interval(m);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic lbmc_pkg::led_out_t predict_leds(led_req_t r);
    lbmc_pkg::led_out_t bits;
    bits = '0;
    if (r.command == lbmc_pkg::CMD_TICK) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (ms_left_q[i] != '0) begin
          ms_left_q[i] = ms_left_q[i] - lbmc_pkg::MS_W'(1);
          if (ms_left_q[i] == '0) expire_led(i);
        end
      end
    end else if (int'(r.led_index) < NUM_LEDS) begin
      set_led_mode(int'(r.led_index), r.mode);
    end
    for (int i = 0; i < NUM_LEDS && i < lbmc_pkg::LED_OUT_W; i++) bits[i] = led_lit_q[i];
    return bits;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_set(logic [lbmc_pkg::LED_IDX_W-1:0] idx, lbmc_pkg::mode_t m);
    led_req_t r;
    r.command   = lbmc_pkg::CMD_SET;
    r.led_index = idx;
    r.mode      = m;
    pending_reqs.push_back(r);
    queued++;
  endtask

  // ticks carry random filler in the unused fields
  task automatic push_ticks(int n);
    led_req_t r;
    for (int k = 0; k < n; k++) begin
      r.command   = lbmc_pkg::CMD_TICK;
      r.led_index = lbmc_pkg::LED_IDX_W'($urandom);
      r.mode      = lbmc_pkg::mode_t'($urandom);
      pending_reqs.push_back(r);
    end
    queued += n;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_leds.size() > 0)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.command   <= lbmc_pkg::CMD_TICK;
      req_ch.led_index <= '0;
      req_ch.mode      <= lbmc_pkg::MODE_OFF;
      cur_req  = '0;
      gap_left = 0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode_q[i] = lbmc_pkg::MODE_OFF;
        led_lit_q[i]  = 1'b0;
        ms_left_q[i]  = '0;
        toggles_q[i]  = '0;
      end
    end else begin
      drv_busy = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_leds.push_back(predict_leds(cur_req));
        drv_busy = 1'b0;
        if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 15);
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          cur_req  = pending_reqs.pop_front();
          drv_busy = 1'b1;
        end
      end
      req_ch.valid     <= drv_busy;
      req_ch.command   <= cur_req.command;
      req_ch.led_index <= cur_req.led_index;
      req_ch.mode      <= cur_req.mode;
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_leds.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no request pending, led_outputs=%b",
                                  results_seen, res_ch.led_outputs));
        end else begin
          want_leds = expected_leds.pop_front();
          if (res_ch.led_outputs !== want_leds)
            flag_mismatch($sformatf("result %0d led_outputs=%b, predicted %b",
                                    results_seen, res_ch.led_outputs, want_leds));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("led_blink_mode_controller verification failed");
        $finish;
      end
    end
  end

  initial begin
    int base;
    int roll;
    int n;
    int t;
    int left;
    queued = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // each mode on either LED, undefined codes, new command over a running timer
    push_ticks(1);
    push_set(1'b0, lbmc_pkg::MODE_ON);
    push_set(1'b1, lbmc_pkg::MODE_ON);
    push_ticks(1);
    push_set(1'b0, lbmc_pkg::MODE_OFF);
    push_set(1'b1, lbmc_pkg::MODE_FL200);
    push_set(1'b0, lbmc_pkg::MODE_ON500);
    push_ticks(2);
    push_set(1'b1, lbmc_pkg::MODE_ON1S);
    push_set(1'b0, lbmc_pkg::MODE_ON2S);
    push_set(1'b1, lbmc_pkg::MODE_FL500);
    push_set(1'b0, lbmc_pkg::MODE_FL2S);
    push_set(1'b1, lbmc_pkg::MODE_BURST);
    push_set(1'b0, lbmc_pkg::mode_t'(int'(lbmc_pkg::MODE_BURST) + 1));
    push_set(1'b1, lbmc_pkg::mode_t'(MODE_LAST_CODE));
    push_ticks(2);
    push_set(1'b0, lbmc_pkg::MODE_OFF);
    push_set(1'b1, lbmc_pkg::MODE_OFF);
    push_ticks(1);

    // sender holds off until the block has fully drained
    wait_drained();

    base = queued;
    while (queued - base < RANDOM_ITEMS) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0)
          push_set(lbmc_pkg::LED_IDX_W'($urandom),
                   lbmc_pkg::mode_t'($urandom_range(int'(lbmc_pkg::MODE_BURST) + 1,
                                                    MODE_LAST_CODE)));
        else
          push_set(lbmc_pkg::LED_IDX_W'($urandom),
                   lbmc_pkg::mode_t'($urandom_range(lbmc_pkg::MODE_OFF,
                                                    lbmc_pkg::MODE_BURST)));
      end
      // tick runs land just around flash edges and timed-on expiries
      roll = $urandom_range(0, 99);
      if (roll < 65) t = $urandom_range(0, 12);
      else if (roll < 90) t = $urandom_range(1, 2) * 200 + $urandom_range(0, 6) - 3;
      else t = $urandom_range(496, 504);
      left = RANDOM_ITEMS - (queued - base);
      if (t > left) t = left;
      if (t < 0) t = 0;
      push_ticks(t);
    end

    // long run without gaps: 500 ms expiry and the first burst toggles
    while (pending_reqs.size() > 0) @(negedge clk);
    calm = 1'b1;
    push_set(1'b0, lbmc_pkg::MODE_BURST);
    push_set(1'b1, lbmc_pkg::MODE_ON500);
    push_ticks(505);
    push_set(1'b1, lbmc_pkg::MODE_ON2S);
    push_ticks(3);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("led_blink_mode_controller verification clean");
    else
      $display("led_blink_mode_controller verification failed");
    $finish;
  end

endmodule

// File: sim.f
src/lbmc_pkg.sv
src/lbmc_if.sv
src/led_blink_mode_controller.sv
tb/tb_led_blink_mode_controller.sv
